/* src/pli_pkg.sv */
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the positional list block.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ELEM_W   = 32;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_READ   = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;  // open a slot at pos, fill it with value
    logic             del;  // close the slot at pos
    logic [IDX_W-1:0] pos;
  } pli_ctrl_t;

endpackage

/* src/pli_cell.sv */
// ----------------------------------------------------------------------------
// pli_cell
// One list slot: holds an element and takes it from the left neighbor,
// the right neighbor or the request value as the broadcast control says.
// ----------------------------------------------------------------------------
module pli_cell import pli_pkg::*; (
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_idx,
  input  pli_ctrl_t         ctrl,
  input  logic [ELEM_W-1:0] value,
  input  logic [ELEM_W-1:0] left_elem,
  input  logic [ELEM_W-1:0] right_elem,
  output logic [ELEM_W-1:0] elem
);

  logic [ELEM_W-1:0] elem_r;
  logic [ELEM_W-1:0] elem_nxt;

  always_comb begin
    elem_nxt = elem_r;
    priority if (ctrl.ins && cell_idx == ctrl.pos) begin
      elem_nxt = value;
    end else if (ctrl.ins && cell_idx > ctrl.pos) begin
      elem_nxt = left_elem;
    end else if (ctrl.del && cell_idx >= ctrl.pos) begin
      elem_nxt = right_elem;
    end else begin
      elem_nxt = elem_r;
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign elem = elem_r;

endmodule

/* src/positional_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of signed 32-bit values with clear, append, read, insert and
// delete at a zero-based position.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: in_tuser carries the operation, in_tdata
//   the index and the value. Each request yields exactly one result on the
//   out_ stream: out_tdata carries the read or deleted element and the new
//   element count, out_tuser the status (ok, invalid position or operation, list full).
//   Storage is a row of 32 cells; insert and delete move every cell at or
//   beyond the position at once toward or away from its neighbor. The result
//   is registered; one request is taken per cycle unless a held result stalls
//   the input. The 32-way read select and the count compare set the cycle time.
//   A result waits in the output register while out_tready is low; a new
//   request is taken in the same cycle the held result leaves, so the input
//   stalls only while a result is held and not taken.
//   Reset empties the list and drops any pending result; element contents
//   are not cleared and are only ever read below the count.
// ----------------------------------------------------------------------------
module positional_list_insert_delete import pli_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [5:0] index, [37:6] value, [39:38] zero
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] data, [37:32] count, [39:38] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic              accept;
  op_t               op;
  logic [5:0]        index;
  logic [ELEM_W-1:0] value;
  logic [IDX_W-1:0]  idx_lo;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0] data_r, data_nxt;
  status_t           status_r, status_nxt;
  logic              full;
  logic              idx_in_list;
  logic              idx_le_len;
  pli_ctrl_t         ctrl;
  logic [ELEM_W-1:0] elem_w [CAPACITY];

  assign op     = op_t'(in_tuser);
  assign index  = in_tdata[5:0];
  assign value  = in_tdata[37:6];
  assign idx_lo = index[IDX_W-1:0];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign full        = (len_r == CNT_W'(CAPACITY));
  assign idx_in_list = (CNT_W'(index) < len_r);
  assign idx_le_len  = (CNT_W'(index) <= len_r);

  always_comb begin
    len_nxt    = len_r;
    data_nxt   = '0;
    status_nxt = ST_OK;
    ctrl       = '0;
    unique case (op)
      OP_CLEAR: begin
        len_nxt = '0;
      end
      OP_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          ctrl.pos = len_r[IDX_W-1:0];
          len_nxt  = len_r + 1'b1;
        end
      end
      OP_READ: begin
        if (idx_in_list) begin
          data_nxt = elem_w[idx_lo];
        end else begin
          status_nxt = ST_INVALID;
        end
      end
      OP_INSERT: begin
        if (!idx_le_len) begin
          status_nxt = ST_INVALID;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          ctrl.pos = idx_lo;
          len_nxt  = len_r + 1'b1;
        end
      end
      OP_DELETE: begin
        if (idx_in_list) begin
          data_nxt = elem_w[idx_lo];
          ctrl.del = 1'b1;
          ctrl.pos = idx_lo;
          len_nxt  = len_r - 1'b1;
        end else begin
          status_nxt = ST_INVALID;
        end
      end
      default: begin
        status_nxt = ST_INVALID;
      end
    endcase
    if (!accept) begin
      ctrl    = '0;
      len_nxt = len_r;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_W-1:0] left_elem;
    logic [ELEM_W-1:0] right_elem;
    if (i == 0) begin : g_first
      assign left_elem = elem_w[i];
    end else begin : g_left
      assign left_elem = elem_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_elem = elem_w[i];
    end else begin : g_right
      assign right_elem = elem_w[i+1];
    end
    pli_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctrl       (ctrl),
      .value      (value),
      .left_elem  (left_elem),
      .right_elem (right_elem),
      .elem       (elem_w[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r   <= data_nxt;
      status_r <= status_nxt;
    end
  end

  logic [CNT_W-1:0] count_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      count_r <= len_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, 6'(count_r), data_r};
  assign out_tuser  = status_r;

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == OP_APPEND && !full |=> len_r == $past(len_r) + 1'b1)
    else $error("append did not grow the list");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[37:32] == 6'(CAPACITY))
    else $error("full status with list not full");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[31:0] == '0)
    else $error("failed request returned data");
`endif

endmodule
